@@ src/qtccf_pkg.sv @@
package qtccf_pkg;

  // One RGB888 pixel, channel 0 red, channel 1 green, channel 2 blue.
  typedef logic [2:0][7:0] pixel_t;

  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;

  localparam int unsigned NUM_PIX   = 4;
  localparam int unsigned NUM_PAIRS = 6;
  localparam int unsigned NUM_CH    = 3;

  // Square of an 8-bit difference, sum of three of those, sum of two of those.
  localparam int unsigned SQ_W   = 16;
  localparam int unsigned DIST_W = 18;
  localparam int unsigned COST_W = 19;
  localparam int unsigned PAIR_W = 3;
  localparam int unsigned GLYPH_W = 14;
  localparam int unsigned FIT_W   = 20;

  typedef logic [SQ_W-1:0]    sq_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [COST_W-1:0]  cost_t;
  typedef logic [PAIR_W-1:0]  pair_idx_t;
  typedef logic [GLYPH_W-1:0] glyph_t;

  // Candidate pairs in trial order: foreground pixel and background pixel.
  localparam logic [1:0] PAIR_FORE [NUM_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_BACK [NUM_PAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

  // Index of the pair that joins two distinct pixels, in either order.
  function automatic pair_idx_t pair_of(input logic [1:0] p, input logic [1:0] q);
    pair_idx_t idx;
    unique case ({p, q})
      4'b00_01, 4'b01_00: idx = 3'd0;
      4'b00_10, 4'b10_00: idx = 3'd1;
      4'b00_11, 4'b11_00: idx = 3'd2;
      4'b01_10, 4'b10_01: idx = 3'd3;
      4'b01_11, 4'b11_01: idx = 3'd4;
      4'b10_11, 4'b11_10: idx = 3'd5;
      default:            idx = 3'd0;
    endcase
    return idx;
  endfunction

  function automatic sq_t sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  // Quadrant glyph code point for a foreground mask.
  function automatic glyph_t glyph_of(input logic [3:0] mask);
    glyph_t g;
    unique case (mask)
      4'h0: g = 14'h0020;
      4'h1: g = 14'h2598;
      4'h2: g = 14'h259D;
      4'h3: g = 14'h2580;
      4'h4: g = 14'h2596;
      4'h5: g = 14'h258C;
      4'h6: g = 14'h259E;
      4'h7: g = 14'h259B;
      4'h8: g = 14'h2597;
      4'h9: g = 14'h259A;
      4'hA: g = 14'h2590;
      4'hB: g = 14'h259C;
      4'hC: g = 14'h2584;
      4'hD: g = 14'h2599;
      4'hE: g = 14'h259F;
      4'hF: g = 14'h2588;
      default: g = 14'h0020;
    endcase
    return g;
  endfunction

endpackage

@@ src/qtccf_ifs.sv @@
interface qtccf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ul_red;
  logic [7:0] ul_green;
  logic [7:0] ul_blue;
  logic [7:0] ur_red;
  logic [7:0] ur_green;
  logic [7:0] ur_blue;
  logic [7:0] ll_red;
  logic [7:0] ll_green;
  logic [7:0] ll_blue;
  logic [7:0] lr_red;
  logic [7:0] lr_green;
  logic [7:0] lr_blue;

  modport source (
    output valid, ul_red, ul_green, ul_blue, ur_red, ur_green, ur_blue,
           ll_red, ll_green, ll_blue, lr_red, lr_green, lr_blue,
    input  ready
  );
  modport sink (
    input  valid, ul_red, ul_green, ul_blue, ur_red, ur_green, ur_blue,
           ll_red, ll_green, ll_blue, lr_red, lr_green, lr_blue,
    output ready
  );
endinterface

interface qtccf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  fore_red;
  logic [7:0]  fore_green;
  logic [7:0]  fore_blue;
  logic [7:0]  back_red;
  logic [7:0]  back_green;
  logic [7:0]  back_blue;
  logic [3:0]  cover_mask;
  logic [13:0] glyph_point;
  logic [19:0] fit_cost;

  modport source (
    output valid, fore_red, fore_green, fore_blue, back_red, back_green, back_blue,
           cover_mask, glyph_point, fit_cost,
    input  ready
  );
  modport sink (
    input  valid, fore_red, fore_green, fore_blue, back_red, back_green, back_blue,
           cover_mask, glyph_point, fit_cost,
    output ready
  );
endinterface

@@ src/quadrant_two_color_cell_fit.sv @@
// Two-color quadrant fit for one 2x2 block of RGB888 pixels per request. The block
// tries the six pixel pairs as foreground and background, assigns every pixel to
// the nearer color by squared RGB distance (a tie goes to the foreground), and
// returns the pair with the lowest summed error together with its 4-bit mask, the
// matching quadrant glyph code point and the cost. A request enters every clock
// cycle while in_ch.ready is high, and its result then moves through the five
// register stages in order before it is offered on out_ch. The stages are: channel
// squares, pair distances, per-pair costs, a first round of cost compares, and
// the final pick into the output register. Each stage holds its own valid bit,
// so a stall on the output fills empty stages first and only then lowers
// in_ch.ready; nothing is dropped or repeated. The block has no state beyond
// the pipeline and needs no setup.
module quadrant_two_color_cell_fit (
  input  logic               clk,
  input  logic               rst_n,
  qtccf_in_if.sink           in_ch,
  qtccf_out_if.source        out_ch
);

  // Stage valid bits and per-stage advance enables. A stage may load when it is
  // empty or when the stage after it loads in the same cycle.
  logic v1_r, v2_r, v3_r, v4_r, out_v_r;
  logic adv1, adv2, adv3, adv4, adv5;

  assign adv5 = !out_v_r || out_ch.ready;
  assign adv4 = !v4_r || adv5;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;

  assign in_ch.ready  = adv1;
  assign out_ch.valid = out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv1) v1_r    <= in_ch.valid;
      if (adv2) v2_r    <= v1_r;
      if (adv3) v3_r    <= v2_r;
      if (adv4) v4_r    <= v3_r;
      if (adv5) out_v_r <= v4_r;
    end
  end

  // Stage 1: gather the pixels and square the channel differences of every pair.
  qtccf_pkg::pixel_t px_in [qtccf_pkg::NUM_PIX];
  qtccf_pkg::pixel_t px1_r [qtccf_pkg::NUM_PIX];
  qtccf_pkg::sq_t    sq1_nxt [qtccf_pkg::NUM_PAIRS][qtccf_pkg::NUM_CH];
  qtccf_pkg::sq_t    sq1_r   [qtccf_pkg::NUM_PAIRS][qtccf_pkg::NUM_CH];

  assign px_in[0] = {in_ch.ul_blue, in_ch.ul_green, in_ch.ul_red};
  assign px_in[1] = {in_ch.ur_blue, in_ch.ur_green, in_ch.ur_red};
  assign px_in[2] = {in_ch.ll_blue, in_ch.ll_green, in_ch.ll_red};
  assign px_in[3] = {in_ch.lr_blue, in_ch.lr_green, in_ch.lr_red};

  always_comb begin
    for (int k = 0; k < qtccf_pkg::NUM_PAIRS; k++) begin
      for (int c = 0; c < qtccf_pkg::NUM_CH; c++) begin
        sq1_nxt[k][c] = qtccf_pkg::sq_diff(px_in[qtccf_pkg::PAIR_FORE[k]][c],
                                           px_in[qtccf_pkg::PAIR_BACK[k]][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      px1_r <= px_in;
      sq1_r <= sq1_nxt;
    end
  end

  // Stage 2: squared RGB distance of every pair of pixels.
  qtccf_pkg::pixel_t px2_r [qtccf_pkg::NUM_PIX];
  qtccf_pkg::dist_t  dist2_nxt [qtccf_pkg::NUM_PAIRS];
  qtccf_pkg::dist_t  dist2_r   [qtccf_pkg::NUM_PAIRS];

  always_comb begin
    for (int k = 0; k < qtccf_pkg::NUM_PAIRS; k++) begin
      dist2_nxt[k] = qtccf_pkg::DIST_W'(sq1_r[k][qtccf_pkg::CH_RED])
                   + qtccf_pkg::DIST_W'(sq1_r[k][qtccf_pkg::CH_GREEN])
                   + qtccf_pkg::DIST_W'(sq1_r[k][qtccf_pkg::CH_BLUE]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      px2_r   <= px1_r;
      dist2_r <= dist2_nxt;
    end
  end

  // Stage 3: cost and mask of each candidate pair. A pixel's distance to itself
  // is zero, so the foreground pixel always lands in the mask.
  qtccf_pkg::pixel_t px3_r [qtccf_pkg::NUM_PIX];
  qtccf_pkg::cost_t  cost3_nxt [qtccf_pkg::NUM_PAIRS];
  qtccf_pkg::cost_t  cost3_r   [qtccf_pkg::NUM_PAIRS];
  logic [3:0]        mask3_nxt [qtccf_pkg::NUM_PAIRS];
  logic [3:0]        mask3_r   [qtccf_pkg::NUM_PAIRS];

  always_comb begin
    qtccf_pkg::dist_t df;
    qtccf_pkg::dist_t db;
    logic [1:0]       f;
    logic [1:0]       b;
    for (int k = 0; k < qtccf_pkg::NUM_PAIRS; k++) begin
      f            = qtccf_pkg::PAIR_FORE[k];
      b            = qtccf_pkg::PAIR_BACK[k];
      cost3_nxt[k] = '0;
      mask3_nxt[k] = '0;
      for (int p = 0; p < qtccf_pkg::NUM_PIX; p++) begin
        df = (2'(p) == f) ? '0 : dist2_r[qtccf_pkg::pair_of(2'(p), f)];
        db = (2'(p) == b) ? '0 : dist2_r[qtccf_pkg::pair_of(2'(p), b)];
        if (df <= db) begin
          mask3_nxt[k][p] = 1'b1;
          cost3_nxt[k]    = cost3_nxt[k] + qtccf_pkg::COST_W'(df);
        end else begin
          cost3_nxt[k]    = cost3_nxt[k] + qtccf_pkg::COST_W'(db);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      px3_r   <= px2_r;
      cost3_r <= cost3_nxt;
      mask3_r <= mask3_nxt;
    end
  end

  // Stage 4: first compare round between neighboring pairs. The later pair
  // replaces the earlier one only on a strictly lower cost.
  localparam int unsigned NUM_HALF = qtccf_pkg::NUM_PAIRS / 2;

  qtccf_pkg::pixel_t    px4_r [qtccf_pkg::NUM_PIX];
  qtccf_pkg::cost_t     cost4_nxt [NUM_HALF];
  qtccf_pkg::cost_t     cost4_r   [NUM_HALF];
  logic [3:0]           mask4_nxt [NUM_HALF];
  logic [3:0]           mask4_r   [NUM_HALF];
  qtccf_pkg::pair_idx_t pair4_nxt [NUM_HALF];
  qtccf_pkg::pair_idx_t pair4_r   [NUM_HALF];

  always_comb begin
    for (int j = 0; j < NUM_HALF; j++) begin
      if (cost3_r[2*j+1] < cost3_r[2*j]) begin
        cost4_nxt[j] = cost3_r[2*j+1];
        mask4_nxt[j] = mask3_r[2*j+1];
        pair4_nxt[j] = qtccf_pkg::PAIR_W'(2*j+1);
      end else begin
        cost4_nxt[j] = cost3_r[2*j];
        mask4_nxt[j] = mask3_r[2*j];
        pair4_nxt[j] = qtccf_pkg::PAIR_W'(2*j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      px4_r   <= px3_r;
      cost4_r <= cost4_nxt;
      mask4_r <= mask4_nxt;
      pair4_r <= pair4_nxt;
    end
  end

  // Stage 5: final pick in trial order, then colors and glyph into the output
  // register.
  qtccf_pkg::cost_t     win_cost;
  logic [3:0]           win_mask;
  qtccf_pkg::pair_idx_t win_pair;
  qtccf_pkg::pixel_t    out_fore_nxt;
  qtccf_pkg::pixel_t    out_back_nxt;

  qtccf_pkg::pixel_t    out_fore_r;
  qtccf_pkg::pixel_t    out_back_r;
  logic [3:0]           out_mask_r;
  qtccf_pkg::glyph_t    out_glyph_r;
  qtccf_pkg::cost_t     out_cost_r;

  always_comb begin
    win_cost = cost4_r[0];
    win_mask = mask4_r[0];
    win_pair = pair4_r[0];
    for (int j = 1; j < NUM_HALF; j++) begin
      if (cost4_r[j] < win_cost) begin
        win_cost = cost4_r[j];
        win_mask = mask4_r[j];
        win_pair = pair4_r[j];
      end
    end
    out_fore_nxt = px4_r[qtccf_pkg::PAIR_FORE[win_pair]];
    out_back_nxt = px4_r[qtccf_pkg::PAIR_BACK[win_pair]];
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      out_fore_r  <= out_fore_nxt;
      out_back_r  <= out_back_nxt;
      out_mask_r  <= win_mask;
      out_glyph_r <= qtccf_pkg::glyph_of(win_mask);
      out_cost_r  <= win_cost;
    end
  end

  assign out_ch.fore_red    = out_fore_r[qtccf_pkg::CH_RED];
  assign out_ch.fore_green  = out_fore_r[qtccf_pkg::CH_GREEN];
  assign out_ch.fore_blue   = out_fore_r[qtccf_pkg::CH_BLUE];
  assign out_ch.back_red    = out_back_r[qtccf_pkg::CH_RED];
  assign out_ch.back_green  = out_back_r[qtccf_pkg::CH_GREEN];
  assign out_ch.back_blue   = out_back_r[qtccf_pkg::CH_BLUE];
  assign out_ch.cover_mask  = out_mask_r;
  assign out_ch.glyph_point = out_glyph_r;
  assign out_ch.fit_cost    = qtccf_pkg::FIT_W'(out_cost_r);

endmodule

@@ src/qtccf_checker.sv @@
module qtccf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  fore_red,
  input logic [7:0]  fore_green,
  input logic [7:0]  fore_blue,
  input logic [7:0]  back_red,
  input logic [7:0]  back_green,
  input logic [7:0]  back_blue,
  input logic [3:0]  cover_mask,
  input logic [13:0] glyph_point,
  input logic [19:0] fit_cost
);

  // Reset empties the pipeline, so no result is offered right after it.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result withdrawn");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({fore_red, fore_green, fore_blue, back_red,
                                         back_green, back_blue, cover_mask,
                                         glyph_point, fit_cost}))
    else $error("stalled result changed");

  // The glyph must always follow the mask of the same result.
  a_glyph_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> glyph_point == qtccf_pkg::glyph_of(cover_mask))
    else $error("glyph does not match mask");

endmodule

bind quadrant_two_color_cell_fit qtccf_checker u_qtccf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .fore_red    (out_ch.fore_red),
  .fore_green  (out_ch.fore_green),
  .fore_blue   (out_ch.fore_blue),
  .back_red    (out_ch.back_red),
  .back_green  (out_ch.back_green),
  .back_blue   (out_ch.back_blue),
  .cover_mask  (out_ch.cover_mask),
  .glyph_point (out_ch.glyph_point),
  .fit_cost    (out_ch.fit_cost)
);
